// File: rtl/core/tzf_pkg.sv
// Package: types, constants and the offset check for the timezone offset fixer.
`timescale 1ns / 1ps
package tzf_pkg;

   typedef logic signed [63:0] seconds_type;
   typedef logic signed [17:0] offset_type;
   typedef logic signed [18:0] guess_type;

   localparam int DAY_SECONDS      = 24 * 3600;
   localparam int QUARTER_SECONDS  = 3600 / 4;
   localparam int HALF_QUARTER     = QUARTER_SECONDS / 2;
   localparam int MATCH_TOLERANCE  = 30;
   localparam int HOUR_SECONDS     = 3600;
   localparam int OFFSET_MIN       = -12 * 3600;
   localparam int OFFSET_MAX       = 14 * 3600;
   localparam int ABS_WIDTH        = 17;
   localparam int QUOT_WIDTH       = 7;
   localparam int RECIP_SHIFT      = 27;
   localparam int RECIP_WIDTH      = 18;
   localparam int PROD_WIDTH       = ABS_WIDTH + RECIP_WIDTH - 1;
   localparam int RECIP_900        = ((2 ** RECIP_SHIFT) + QUARTER_SECONDS - 1) / QUARTER_SECONDS;
   localparam int ODD_COUNT        = 17;

   localparam guess_type ODD_OFFSETS [ODD_COUNT] = '{
      -19'sd34200, -19'sd16200, -19'sd12600, -19'sd9000, 19'sd12600, 19'sd16200,
      19'sd19800, 19'sd20700, 19'sd23400, 19'sd30600, 19'sd31500, 19'sd34200,
      19'sd35100, 19'sd37800, 19'sd41400, 19'sd45900, 19'sd49500
   };

   // whole hours inside the legal span, or one of the listed half/quarter hours
   function automatic logic offset_valid(input guess_type g);
      logic hit;
      hit = 1'b0;
      for (int k = OFFSET_MIN / HOUR_SECONDS; k <= OFFSET_MAX / HOUR_SECONDS; k++) begin
         if (g == guess_type'(k * HOUR_SECONDS)) hit = 1'b1;
      end
      for (int i = 0; i < ODD_COUNT; i++) begin
         if (g == ODD_OFFSETS[i]) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

// File: rtl/core/tzf_req_if.sv
// Input channel: timestamp, recorded offset and current time.
`timescale 1ns / 1ps
interface tzf_req_if;
   import tzf_pkg::*;
   logic        valid;
   logic        ready;
   seconds_type stamp_seconds;
   offset_type  stamp_offset;
   seconds_type current_seconds;

   modport source (output valid, stamp_seconds, stamp_offset, current_seconds, input ready);
   modport sink (input valid, stamp_seconds, stamp_offset, current_seconds, output ready);
endinterface

// File: rtl/core/tzf_rsp_if.sv
// Result channel: fixed timestamp, fixed offset and found flag.
`timescale 1ns / 1ps
interface tzf_rsp_if;
   import tzf_pkg::*;
   logic        valid;
   logic        ready;
   seconds_type fixed_seconds;
   offset_type  fixed_offset;
   logic        guess_found;

   modport source (output valid, fixed_seconds, fixed_offset, guess_found, input ready);
   modport sink (input valid, fixed_seconds, fixed_offset, guess_found, output ready);
endinterface

// File: rtl/core/timezone_offset_guess_and_fix.sv
// Timezone offset guess and fix: three-register pipeline. It takes one item per cycle
// while the result channel does not hold it back; an accepted item passes through the
// input register, a register after the divide-by-900 reciprocal multiply and the
// result register before its result shows. Each register stage loads whenever the stage
// after it is empty or moving, so a result waiting on rsp_ch does not stop
// earlier empty stages from filling. No state carries from one item to the next.
`timescale 1ns / 1ps
module timezone_offset_guess_and_fix (
   input logic      clock,
   input logic      reset,
   tzf_req_if.sink  req_ch,
   tzf_rsp_if.source rsp_ch
);
   import tzf_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   seconds_type in_sec_ff, in_cur_ff;
   offset_type  in_off_ff;

   // mid stage
   logic                   mid_valid_ff, mid_valid_in;
   seconds_type            mid_sec_ff;
   offset_type             mid_off_ff;
   logic                   mid_in_day_ff;
   logic                   mid_neg_ff;
   logic [ABS_WIDTH-1:0]   mid_abs_ff;
   logic [PROD_WIDTH-1:0]  mid_prod_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   seconds_type rsp_sec_ff, rsp_sec_in;
   offset_type  rsp_off_ff, rsp_off_in;
   logic        rsp_found_ff, rsp_found_in;

   logic in_load, mid_load, rsp_load;

   assign rsp_load = !rsp_valid_ff || rsp_ch.ready;
   assign mid_load = !mid_valid_ff || rsp_load;
   assign in_load  = !in_valid_ff || mid_load;

   assign req_ch.ready = in_load;

   assign in_valid_in  = in_load  ? req_ch.valid : in_valid_ff;
   assign mid_valid_in = mid_load ? in_valid_ff  : mid_valid_ff;
   assign rsp_valid_in = rsp_load ? mid_valid_ff : rsp_valid_ff;

   // difference, day window, magnitude and reciprocal product
   seconds_type           diff;
   logic                  in_day, neg;
   logic [ABS_WIDTH-1:0]  abs_diff, biased;
   logic [PROD_WIDTH-1:0] prod;

   always_comb begin
      diff     = in_cur_ff - in_sec_ff;
      in_day   = (diff > -seconds_type'(DAY_SECONDS)) && (diff < seconds_type'(DAY_SECONDS));
      neg      = diff[63];
      abs_diff = neg ? ABS_WIDTH'(~diff[ABS_WIDTH-1:0] + 1'b1) : diff[ABS_WIDTH-1:0];
      biased   = abs_diff + ABS_WIDTH'(HALF_QUARTER);
      prod     = PROD_WIDTH'(biased) * PROD_WIDTH'(RECIP_900);
   end

   // rounding check, guessed offset and shifted seconds
   logic [QUOT_WIDTH-1:0] quot;
   logic [ABS_WIDTH-1:0]  rounded_mag, dev_mag;
   logic                  dev_ok;
   guess_type             off_ext, rounded_ext, guess;
   logic signed [19:0]    delta;
   offset_type            implied;

   always_comb begin
      quot        = mid_prod_ff[RECIP_SHIFT +: QUOT_WIDTH];
      rounded_mag = ABS_WIDTH'(quot) * ABS_WIDTH'(QUARTER_SECONDS);
      dev_mag     = (mid_abs_ff >= rounded_mag) ? mid_abs_ff - rounded_mag
                                                : rounded_mag - mid_abs_ff;
      dev_ok      = dev_mag <= ABS_WIDTH'(MATCH_TOLERANCE);
      off_ext     = guess_type'(mid_off_ff);
      rounded_ext = signed'({2'b00, rounded_mag});
      guess       = mid_neg_ff ? off_ext + rounded_ext : off_ext - rounded_ext;
      implied     = (mid_off_ff == -18'sd1) ? '0 : mid_off_ff;
      delta       = 20'(guess) - 20'(implied);
      rsp_found_in = mid_in_day_ff && dev_ok && offset_valid(guess);
      if (rsp_found_in) begin
         rsp_sec_in = mid_sec_ff - seconds_type'(delta);
         rsp_off_in = guess[17:0];
      end else begin
         rsp_sec_in = mid_sec_ff;
         rsp_off_in = mid_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_sec_ff <= req_ch.stamp_seconds;
         in_off_ff <= req_ch.stamp_offset;
         in_cur_ff <= req_ch.current_seconds;
      end
      if (mid_load) begin
         mid_sec_ff    <= in_sec_ff;
         mid_off_ff    <= in_off_ff;
         mid_in_day_ff <= in_day;
         mid_neg_ff    <= neg;
         mid_abs_ff    <= abs_diff;
         mid_prod_ff   <= prod;
      end
      if (rsp_load) begin
         rsp_sec_ff   <= rsp_sec_in;
         rsp_off_ff   <= rsp_off_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.fixed_seconds = rsp_sec_ff;
   assign rsp_ch.fixed_offset  = rsp_off_ff;
   assign rsp_ch.guess_found   = rsp_found_ff;

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> in_valid_ff)
      else $error("accepted item did not reach input stage");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !mid_load |=> in_valid_ff && $stable(in_sec_ff))
      else $error("input stage item lost while mid stage blocked");

   a_day_magnitude: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_in_day_ff |-> mid_abs_ff < ABS_WIDTH'(DAY_SECONDS))
      else $error("in-day difference magnitude out of range");

   a_found_in_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |->
         rsp_off_ff >= offset_type'(OFFSET_MIN) && rsp_off_ff <= offset_type'(OFFSET_MAX))
      else $error("guessed offset outside legal span");

endmodule

// File: tb/timezone_offset_guess_and_fix_test.sv
// Self-checking testbench for the timezone offset guess and fix pipeline.
`timescale 1ns / 1ps
module timezone_offset_guess_and_fix_test;
   import tzf_pkg::*;

   typedef struct {
      seconds_type stamp_seconds;
      offset_type  stamp_offset;
      seconds_type current_seconds;
   } stamp_item_type;

   typedef struct {
      seconds_type fixed_seconds;
      offset_type  fixed_offset;
      logic        guess_found;
   } stamp_fix_type;

   localparam longint DAY_SPAN     = 86400;
   localparam longint QUARTER_SPAN = 900;
   localparam longint SLACK        = 30;
   localparam longint ZONE_LOW     = -43200;
   localparam longint ZONE_HIGH    = 50400;
   localparam longint HOUR_SPAN    = 3600;
   localparam int     RANDOM_ITEMS = 850;
   localparam int     STALL_AT     = 300;
   localparam int     STALL_CYCLES = 250;
   localparam int     DRAIN_AT     = 600;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     ODD_ZONES [17] = '{
      -34200, -16200, -12600, -9000, 12600, 16200, 19800, 20700, 23400,
      30600, 31500, 34200, 35100, 37800, 41400, 45900, 49500
   };
   localparam seconds_type SEC_MAX = {1'b0, {63{1'b1}}};
   localparam seconds_type SEC_MIN = {1'b1, 63'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   tzf_req_if req_ch ();
   tzf_rsp_if rsp_ch ();

   timezone_offset_guess_and_fix u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stamp_item_type pending_stamps [$];
   stamp_fix_type  expected_fixes [$];
   int          sent_count  = 0;
   int          fault_count = 0;
   int          cycle_count = 0;
   int          send_idle   = 0;
   int          take_idle   = 0;
   int          hold_count  = 0;
   logic        long_hold   = 1'b0;
   logic        stall_done  = 1'b0;

   function automatic logic plausible_zone(longint z);
      if (z < ZONE_LOW || z > ZONE_HIGH) return 1'b0;
      if (z % HOUR_SPAN == 0) return 1'b1;
      foreach (ODD_ZONES[i]) begin
         if (longint'(ODD_ZONES[i]) == z) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic stamp_fix_type guess_fix(stamp_item_type it);
      stamp_fix_type fix;
      longint     drift;
      longint     rounded;
      longint     dev;
      longint     zone;
      longint     prior;
      fix.fixed_seconds = it.stamp_seconds;
      fix.fixed_offset  = it.stamp_offset;
      fix.guess_found   = 1'b0;
      drift = it.current_seconds - it.stamp_seconds;
      if (drift <= -DAY_SPAN || drift >= DAY_SPAN) return fix;
      if (drift < 0) rounded = ((drift - QUARTER_SPAN / 2) / QUARTER_SPAN) * QUARTER_SPAN;
      else rounded = ((drift + QUARTER_SPAN / 2) / QUARTER_SPAN) * QUARTER_SPAN;
      dev = drift - rounded;
      if (dev < -SLACK || dev > SLACK) return fix;
      zone = longint'(it.stamp_offset) - rounded;
      if (!plausible_zone(zone)) return fix;
      prior = (it.stamp_offset == -1) ? 0 : longint'(it.stamp_offset);
      fix.fixed_seconds = it.stamp_seconds - seconds_type'(zone - prior);
      fix.fixed_offset  = offset_type'(zone);
      fix.guess_found   = 1'b1;
      return fix;
   endfunction

   function automatic void push_stamp(seconds_type s, int off, longint drift);
      stamp_item_type it;
      it.stamp_seconds   = s;
      it.stamp_offset    = offset_type'(off);
      it.current_seconds = s + seconds_type'(drift);
      pending_stamps.push_back(it);
   endfunction

   function automatic seconds_type random_seconds();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return seconds_type'(longint'($urandom_range(0, 4000000)) - 2000000);
      if (pick == 1) return SEC_MAX - seconds_type'($urandom_range(0, 100000));
      if (pick == 2) return SEC_MIN + seconds_type'($urandom_range(0, 100000));
      return {$urandom, $urandom};
   endfunction

   // mostly well-formed: target zone plus a quarter-hour drift, small deviation; else random
   function automatic void push_random_stamp();
      int          zone;
      int          prior;
      int          q;
      int          dev;
      seconds_type s;
      s = random_seconds();
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 6))
            0, 1, 2: zone = (int'($urandom_range(0, 26)) - 12) * 3600;
            3, 4, 5: zone = ODD_ZONES[$urandom_range(0, 16)];
            default: zone = (int'($urandom_range(0, 120)) - 60) * 900;
         endcase
         do begin
            q = int'($urandom_range(0, 192)) - 96;
            prior = zone + q * 900;
         end while (prior < -86400 || prior > 86400);
         if ($urandom_range(0, 9) == 0) prior = -1;
         if ($urandom_range(0, 4) != 0) dev = int'($urandom_range(0, 60)) - 30;
         else dev = int'($urandom_range(0, 120)) - 60;
         push_stamp(s, prior, longint'(q * 900 + dev));
      end else begin
         prior = int'($urandom_range(0, 172800)) - 86400;
         if ($urandom_range(0, 1) == 0) push_stamp(s, prior, {$urandom, $urandom});
         else push_stamp(s, prior, longint'($urandom_range(0, 200000)) - 100000);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if ((sent_count / 128) % 4 == 2) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.stamp_seconds   = '0;
      req_ch.stamp_offset    = '0;
      req_ch.current_seconds = '0;
      rsp_ch.ready           = 1'b0;

      push_stamp(0, 0, 0);
      push_stamp(SEC_MIN, 0, -1);
      push_stamp(SEC_MAX, 3600, 1);
      push_stamp(0, 0, SEC_MAX);
      push_stamp(5, 0, SEC_MIN);
      push_stamp(1000, 0, 86399);
      push_stamp(1000, 0, 86400);
      push_stamp(1000, 0, -86399);
      push_stamp(1000, 0, -86400);
      push_stamp(77, 86400, 86399);
      push_stamp(77, -86400, -86399);
      push_stamp(123456, -1, 0);
      push_stamp(0, 0, 450);
      push_stamp(0, 0, -450);
      push_stamp(0, 0, 3630);
      push_stamp(0, 0, 3631);
      push_stamp(0, 0, -3570);
      push_stamp(0, 0, -3569);
      push_stamp(0, 0, 43200);
      push_stamp(0, 0, -50400);
      push_stamp(0, 0, 46800);
      push_stamp(0, 0, -20700);
      push_stamp(0, 0, -45900);
      push_stamp(0, 0, 34200);
      push_stamp(0, 0, -22500);
      push_stamp(SEC_MIN + 10, 0, -50400);
      push_stamp(SEC_MAX - 5, 0, 43200);
      repeat (RANDOM_ITEMS) push_random_stamp();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_stamps.size() != 0 || expected_fixes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("timezone_offset_guess_and_fix_test OK");
      end else begin
         $display("timezone_offset_guess_and_fix_test NOT OK");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timezone_offset_guess_and_fix_test NOT OK");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_fixes.push_back(guess_fix(pending_stamps.pop_front()));
            sent_count++;
            send_idle = pick_gap();
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the item until taken
         end else if (send_idle > 0 || pending_stamps.size() == 0 ||
                      (sent_count == DRAIN_AT && expected_fixes.size() != 0)) begin
            req_ch.valid <= 1'b0;
            if (send_idle > 0) send_idle--;
         end else begin
            req_ch.valid           <= 1'b1;
            req_ch.stamp_seconds   <= pending_stamps[0].stamp_seconds;
            req_ch.stamp_offset    <= pending_stamps[0].stamp_offset;
            req_ch.current_seconds <= pending_stamps[0].current_seconds;
         end
      end
   end

   // one long receiver hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         long_hold  <= 1'b0;
         stall_done <= 1'b0;
         hold_count <= 0;
      end else if (!stall_done && sent_count >= STALL_AT) begin
         if (hold_count < STALL_CYCLES) begin
            long_hold  <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            long_hold  <= 1'b0;
            stall_done <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_fixes.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result: seconds %0d offset %0d found %0b",
                           rsp_ch.fixed_seconds, rsp_ch.fixed_offset, rsp_ch.guess_found);
            end else begin
               stamp_fix_type want;
               want = expected_fixes.pop_front();
               if (rsp_ch.fixed_seconds !== want.fixed_seconds ||
                   rsp_ch.fixed_offset !== want.fixed_offset ||
                   rsp_ch.guess_found !== want.guess_found) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                              want.fixed_seconds, want.fixed_offset, want.guess_found,
                              rsp_ch.fixed_seconds, rsp_ch.fixed_offset,
                              rsp_ch.guess_found);
               end
            end
         end
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_idle > 0) begin
            rsp_ch.ready <= 1'b0;
            take_idle--;
         end else begin
            rsp_ch.ready <= 1'b1;
            take_idle = pick_gap();
         end
      end
   end

endmodule

// File: sim.f
rtl/core/tzf_pkg.sv
rtl/core/tzf_req_if.sv
rtl/core/tzf_rsp_if.sv
rtl/core/timezone_offset_guess_and_fix.sv
tb/timezone_offset_guess_and_fix_test.sv
